@@ hdl/wwd_pkg.sv @@
// Shared types and constants for the wildcard word dictionary.
`timescale 1ns / 1ps
`default_nettype none

package wwd_pkg;

  // Field widths fixed by the largest supported word length of 64 letters.
  localparam int POS_W = 6;
  localparam int LEN_W = 7;

  localparam logic [4:0] WILDCARD = 5'd26;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic       req_type;
    logic [4:0] char_code;
    logic       char_last;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } rsp_t;

  // One character moving down the row of entry cells, with the verdicts
  // gathered so far for its request.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [4:0] code;
    pos_t       pos;
    logic       store;
    logic       last;
    logic       too_long;
    len_t       len;
    logic       found;
    logic       dup;
    logic       seen_free;
  } tok_t;

endpackage

`default_nettype wire

@@ hdl/wwd_front.sv @@
// Request front end: tracks the character position and the over-long flag.
`timescale 1ns / 1ps
`default_nettype none

module wwd_front #(
  parameter int MAX_LEN = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           req_valid,
  input  wire wwd_pkg::req_t  req_data,
  output wwd_pkg::tok_t       tok,
  output wwd_pkg::pos_t       ahead_pos
);

  localparam int LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0] char_pos;
  logic          too_long;
  logic          accept;
  logic          drop;
  logic [LW-1:0] len_after;
  wwd_pkg::tok_t tok_next;

  assign accept    = req_valid && adv;
  assign drop      = too_long || (char_pos >= LW'(MAX_LEN));
  assign len_after = drop ? char_pos : char_pos + LW'(1);
  assign ahead_pos = wwd_pkg::pos_t'(char_pos);

  always_comb begin
    tok_next           = '0;
    tok_next.valid     = accept;
    tok_next.kind      = req_data.req_type;
    tok_next.code      = req_data.char_code;
    tok_next.pos       = wwd_pkg::pos_t'(char_pos);
    tok_next.store     = !drop;
    tok_next.last      = req_data.char_last;
    tok_next.too_long  = drop;
    tok_next.len       = wwd_pkg::len_t'(len_after);
    tok_next.found     = 1'b0;
    tok_next.dup       = 1'b0;
    tok_next.seen_free = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos <= '0;
      too_long <= 1'b0;
      tok      <= '0;
    end else if (adv) begin
      tok <= tok_next;
      if (accept) begin
        if (req_data.char_last) begin
          char_pos <= '0;
          too_long <= 1'b0;
        end else begin
          char_pos <= len_after;
          too_long <= drop;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/wwd_cell.sv @@
// One dictionary entry: its stored word, length, and running match state.
`timescale 1ns / 1ps
`default_nettype none

module wwd_cell #(
  parameter int MAX_LEN = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire wwd_pkg::tok_t  tok_in,
  input  wire wwd_pkg::pos_t  ahead_pos,
  output wwd_pkg::tok_t       tok_out
);

  localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [4:0]    word_mem [MAX_LEN];
  logic [4:0]    rd_char;
  logic          entry_valid;
  wwd_pkg::len_t entry_len;
  logic          match;
  logic          exact;

  logic [PW-1:0] rd_addr;
  logic [PW-1:0] wr_addr;
  logic          target;
  logic          wr_en;
  logic          in_range;
  logic          hit;
  logic          match_now;
  logic          exact_now;
  logic          len_eq;
  logic          commit;
  wwd_pkg::tok_t tok_next;

  assign rd_addr  = ahead_pos[PW-1:0];
  assign wr_addr  = tok_in.pos[PW-1:0];
  // The first empty entry along the row takes the characters as they pass.
  assign target   = !entry_valid && !tok_in.seen_free;
  assign wr_en    = adv && tok_in.valid && tok_in.store && target;
  assign in_range = entry_valid && (wwd_pkg::len_t'(tok_in.pos) < entry_len);
  assign hit      = (rd_char == tok_in.code);
  assign len_eq   = (entry_len == tok_in.len);

  assign match_now = match &&
    (!tok_in.store || (in_range && (hit || tok_in.code == wwd_pkg::WILDCARD)));
  assign exact_now = exact && (!tok_in.store || (in_range && hit));

  // Valid entries sit ahead of the empty one, so dup is complete here.
  assign commit = tok_in.valid && tok_in.last && target && !tok_in.too_long &&
                  (tok_in.kind == wwd_pkg::REQ_ADD) && !tok_in.dup;

  always_comb begin
    tok_next           = tok_in;
    tok_next.found     = tok_in.found ||
                         (tok_in.last && match_now && entry_valid && len_eq);
    tok_next.dup       = tok_in.dup ||
                         (tok_in.last && exact_now && entry_valid && len_eq);
    tok_next.seen_free = tok_in.seen_free || !entry_valid;
  end

  // The read address comes from the neighbor's input, so the read is issued in the cycle before the character arrives.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[wr_addr] <= tok_in.code;
    end
    if (adv) begin
      rd_char <= (wr_en && wr_addr == rd_addr) ? tok_in.code : word_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && commit) begin
      entry_len <= tok_in.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      match       <= 1'b1;
      exact       <= 1'b1;
      tok_out     <= '0;
    end else if (adv) begin
      tok_out <= tok_next;
      if (tok_in.valid) begin
        if (tok_in.last) begin
          match <= 1'b1;
          exact <= 1'b1;
          if (commit) begin
            entry_valid <= 1'b1;
          end
        end else begin
          match <= match_now;
          exact <= exact_now;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/wildcard_word_dictionary_top.sv @@
// Top level of the wildcard word dictionary: front end, entry row, output skid.
`timescale 1ns / 1ps
`default_nettype none

// Requests enter one character per beat, and a new character is taken every
// cycle while the output side keeps up. Each character flows through a row of
// WORDS entry cells, one cell per cycle unless stalled, and a result passes the
// front end register, each cell and the output register; only the last character
// of a request yields a result beat. Each cell keeps its word in a small memory
// whose read is issued ahead of the character, and the first empty cell captures
// the characters of an add as they pass. A two-entry output register and skid
// stage let the row keep moving for one result beyond a stalled output.
module wildcard_word_dictionary_top #(
  parameter int WORDS   = 64,
  parameter int MAX_LEN = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire wwd_pkg::req_t  req_data,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output wwd_pkg::rsp_t       rsp_data
);

  wwd_pkg::tok_t chain [WORDS+1];
  wwd_pkg::pos_t ahead [WORDS];
  wwd_pkg::pos_t front_ahead;
  wwd_pkg::tok_t tail;
  wwd_pkg::rsp_t res;
  wwd_pkg::rsp_t skid_data;
  logic          skid_valid;
  logic          adv;
  logic          res_valid;
  logic          take;

  assign adv       = !skid_valid;
  assign req_stall = !adv;

  wwd_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req_data  (req_data),
    .tok       (chain[0]),
    .ahead_pos (front_ahead)
  );

  for (genvar k = 0; k < WORDS; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign ahead[k] = front_ahead;
    end else begin : g_rest
      assign ahead[k] = chain[k-1].pos;
    end

    wwd_cell #(.MAX_LEN(MAX_LEN)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .tok_in    (chain[k]),
      .ahead_pos (ahead[k]),
      .tok_out   (chain[k+1])
    );
  end

  assign tail      = chain[WORDS];
  assign res_valid = adv && tail.valid && tail.last;
  assign take      = rsp_valid && !rsp_stall;

  always_comb begin
    res.found = !tail.too_long && (tail.kind == wwd_pkg::REQ_SEARCH) && tail.found;
    priority if (tail.too_long) begin
      res.status = wwd_pkg::ST_TOO_LONG;
    end else if (tail.kind == wwd_pkg::REQ_ADD && !tail.dup && !tail.seen_free) begin
      res.status = wwd_pkg::ST_FULL;
    end else begin
      res.status = wwd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (rsp_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        rsp_valid <= 1'b1;
      end
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        rsp_data <= skid_data;
      end
    end else if (res_valid) begin
      if (rsp_valid && !take) begin
        skid_data <= res;
      end else begin
        rsp_data <= res;
      end
    end
  end

endmodule

`default_nettype wire
